// ----- rtl/core/dstq_pkg.sv -----
// ----------------------------------------------------------------------------
// dstq_pkg: shared types and codes of the deadline sorted job timer queue
// Request and result item layouts, request and result codes, register indexes
// and the widths of the shared divider.
// ----------------------------------------------------------------------------
package dstq_pkg;

  // Request codes.
  localparam logic [1:0] REQ_START    = 2'd0;
  localparam logic [1:0] REQ_DISPATCH = 2'd1;
  localparam logic [1:0] REQ_DISARM   = 2'd2;

  // Result codes.
  localparam logic [2:0] KIND_QUEUED  = 3'd0;
  localparam logic [2:0] KIND_REFUSED = 3'd1;
  localparam logic [2:0] KIND_EXPIRED = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIRECT_THR = 2'd0;
  localparam logic [1:0] CFG_TIMER_THR  = 2'd1;
  localparam logic [1:0] CFG_US_PER_TICK = 2'd2;
  localparam logic [1:0] CFG_COUNTER_TOP = 2'd3;

  // Divider widths: remaining time over microseconds per tick.
  localparam int DIV_W     = 20;
  localparam int DSR_W     = 11;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  job_id;
    logic [31:0] expire_time;
    logic [31:0] now_us;
    logic [7:0]  timer_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] expired_job;
    logic       compare_armed;
    logic [7:0] compare_value;
    logic       last;
  } out_item_t;

endpackage

// ----- rtl/core/deadline_sorted_job_timer_queue_unit.sv -----
// ----------------------------------------------------------------------------
// deadline_sorted_job_timer_queue_unit: sorted deadline timer queue
// Keeps job ids sorted by wrapping expiry time, expires, arms and dispatches.
// ----------------------------------------------------------------------------
// The block takes one request at a time and is not ready while it works. A
// start request walks the table from the tail one entry per cycle, checking
// for a duplicate id and finding the sorted slot; when it arms the compare
// value it waits for the shared restoring divider, which produces one
// quotient bit per cycle. A dispatch request handles the expired jobs at the
// head one by one, and also waits for the divider when it arms the compare
// value. A disarm request clears the armed job and gives no result. Each
// result passes through the output register; the table needs no clearing
// pass after reset.
module deadline_sorted_job_timer_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dstq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dstq_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_data
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_DHEAD  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [2:0]          ret_r, ret_nxt;
  dstq_pkg::in_item_t  req_r, req_nxt;
  logic [31:0]         diff_r, diff_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic                moving_r, moving_nxt;
  logic                dup_r, dup_nxt;
  logic                disp_r, disp_nxt;
  logic [7:0]          arm_job_r, arm_job_nxt;
  logic [31:0]         arm_exp_r, arm_exp_nxt;
  dstq_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  dstq_pkg::out_item_t out_data_r, out_data_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                armed_valid_r, armed_valid_nxt;
  logic [7:0]          armed_job_r, armed_job_nxt;
  logic [31:0]         armed_exp_r, armed_exp_nxt;
  logic [19:0]         direct_r;
  logic [19:0]         timer_r;
  logic [10:0]         upt_r;
  logic [7:0]          top_r;

  logic [7:0]          tab_job_r [QUEUE_DEPTH];
  logic [31:0]         tab_exp_r [QUEUE_DEPTH];

  logic                ins_en;
  logic [CW-1:0]       ins_pos;
  logic                pop_en;
  logic                div_start;
  logic [19:0]         div_dvd;
  logic                div_done;
  logic [19:0]         div_q;
  logic [10:0]         div_dsr;

  logic                in_fire;
  logic                out_free;
  logic [31:0]         scan_sd;
  logic [31:0]         hd_diff;
  logic [31:0]         new_vs_armed;
  logic [31:0]         head_vs_armed;
  logic                d_lt_direct, d_lt_timer;
  logic                h_lt_direct, h_lt_timer;
  logic [20:0]         cmp_sum;
  logic [20:0]         cmp_wrap;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Wrap-safe differences and threshold compares.
  assign scan_sd       = tab_exp_r[idx_r] - req_r.expire_time;
  assign hd_diff       = tab_exp_r[0] - req_r.now_us;
  assign new_vs_armed  = req_r.expire_time - armed_exp_r;
  assign head_vs_armed = tab_exp_r[0] - armed_exp_r;
  assign d_lt_direct   = $signed(diff_r) < $signed({12'd0, direct_r});
  assign d_lt_timer    = $signed(diff_r) < $signed({12'd0, timer_r});
  assign h_lt_direct   = $signed(hd_diff) < $signed({12'd0, direct_r});
  assign h_lt_timer    = $signed(hd_diff) < $signed({12'd0, timer_r});

  // Compare value: timer count plus ticks, wrapped once by the period.
  assign cmp_sum  = {13'd0, req_r.timer_count} + {1'b0, div_q};
  assign cmp_wrap = (cmp_sum > {13'd0, top_r}) ? (cmp_sum - {13'd0, top_r}) : cmp_sum;

  assign div_dsr = (upt_r == 11'd0) ? 11'd1 : upt_r;
  assign div_dvd = (state_r == ST_DHEAD) ? hd_diff[19:0] : diff_r[19:0];

  dstq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // Request sequencer.
  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    req_nxt         = req_r;
    diff_nxt        = diff_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    moving_nxt      = moving_r;
    dup_nxt         = dup_r;
    disp_nxt        = disp_r;
    arm_job_nxt     = arm_job_r;
    arm_exp_nxt     = arm_exp_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    cnt_nxt         = cnt_r;
    armed_valid_nxt = armed_valid_r;
    armed_job_nxt   = armed_job_r;
    armed_exp_nxt   = armed_exp_r;
    ins_en          = 1'b0;
    ins_pos         = pos_r;
    pop_en          = 1'b0;
    div_start       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt  = in_data;
          diff_nxt = in_data.expire_time - in_data.now_us;
          case (in_data.req_type)
            dstq_pkg::REQ_START: begin
              dup_nxt    = 1'b0;
              moving_nxt = 1'b1;
              pos_nxt    = cnt_r;
              if (cnt_r == '0) begin
                state_nxt = ST_DECIDE;
              end else begin
                idx_nxt   = IW'(cnt_r - CW'(1));
                state_nxt = ST_SCAN;
              end
            end
            dstq_pkg::REQ_DISPATCH: begin
              state_nxt = ST_DHEAD;
            end
            dstq_pkg::REQ_DISARM: begin
              armed_valid_nxt = 1'b0;
              armed_job_nxt   = '0;
              armed_exp_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk from the tail: duplicate check and sorted slot.
      ST_SCAN: begin
        if (tab_job_r[idx_r] == req_r.job_id) begin
          dup_nxt = 1'b1;
        end
        if (moving_r) begin
          if (!scan_sd[31]) begin
            pos_nxt = CW'(idx_r);
          end else begin
            moving_nxt = 1'b0;
          end
        end
        if (idx_r == '0) begin
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      ST_DECIDE: begin
        res_nxt.expired_job   = req_r.job_id;
        res_nxt.compare_armed = 1'b0;
        res_nxt.compare_value = '0;
        res_nxt.last          = 1'b1;
        ret_nxt               = ST_IDLE;
        state_nxt             = ST_EMIT;
        if (dup_r) begin
          res_nxt.result_kind = dstq_pkg::KIND_REFUSED;
        end else if (d_lt_direct) begin
          res_nxt.result_kind = dstq_pkg::KIND_EXPIRED;
        end else if (cnt_r == CW'(QUEUE_DEPTH)) begin
          res_nxt.result_kind = dstq_pkg::KIND_FULL;
        end else if (d_lt_timer && (!armed_valid_r || new_vs_armed[31])) begin
          arm_job_nxt = req_r.job_id;
          arm_exp_nxt = req_r.expire_time;
          disp_nxt    = 1'b0;
          div_start   = 1'b1;
          state_nxt   = ST_DIV;
        end else begin
          res_nxt.result_kind = dstq_pkg::KIND_QUEUED;
          ins_en  = 1'b1;
          ins_pos = pos_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Dispatch: look at the head job.
      ST_DHEAD: begin
        res_nxt.expired_job   = '0;
        res_nxt.compare_armed = 1'b0;
        res_nxt.compare_value = '0;
        res_nxt.last          = 1'b1;
        res_nxt.result_kind   = dstq_pkg::KIND_DONE;
        ret_nxt               = ST_IDLE;
        state_nxt             = ST_EMIT;
        if (cnt_r != '0) begin
          if (h_lt_direct) begin
            res_nxt.result_kind = dstq_pkg::KIND_EXPIRED;
            res_nxt.expired_job = tab_job_r[0];
            res_nxt.last        = 1'b0;
            pop_en  = 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            ret_nxt = ST_DHEAD;
          end else if (h_lt_timer && (!armed_valid_r || head_vs_armed[31])) begin
            arm_job_nxt = tab_job_r[0];
            arm_exp_nxt = tab_exp_r[0];
            disp_nxt    = 1'b1;
            div_start   = 1'b1;
            state_nxt   = ST_DIV;
          end
        end
      end

      // Wait for the quotient, then arm the compare value.
      ST_DIV: begin
        if (div_done) begin
          armed_valid_nxt       = 1'b1;
          armed_job_nxt         = arm_job_r;
          armed_exp_nxt         = arm_exp_r;
          res_nxt.result_kind   = disp_r ? dstq_pkg::KIND_DONE : dstq_pkg::KIND_QUEUED;
          res_nxt.expired_job   = arm_job_r;
          res_nxt.compare_armed = 1'b1;
          res_nxt.compare_value = cmp_wrap[7:0];
          res_nxt.last          = 1'b1;
          ret_nxt               = ST_IDLE;
          state_nxt             = ST_EMIT;
          if (!disp_r) begin
            ins_en  = 1'b1;
            ins_pos = '0;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      // Hand the result to the output register.
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ret_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
      armed_valid_r <= 1'b0;
      armed_job_r   <= '0;
      armed_exp_r   <= '0;
      direct_r      <= 20'd200;
      timer_r       <= 20'd2000;
      upt_r         <= 11'd4;
      top_r         <= 8'd249;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
      armed_valid_r <= armed_valid_nxt;
      armed_job_r   <= armed_job_nxt;
      armed_exp_r   <= armed_exp_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dstq_pkg::CFG_DIRECT_THR:  direct_r <= cfg_data;
          dstq_pkg::CFG_TIMER_THR:   timer_r  <= cfg_data;
          dstq_pkg::CFG_US_PER_TICK: upt_r    <= cfg_data[10:0];
          dstq_pkg::CFG_COUNTER_TOP: top_r    <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    req_r      <= req_nxt;
    diff_r     <= diff_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    moving_r   <= moving_nxt;
    dup_r      <= dup_nxt;
    disp_r     <= disp_nxt;
    arm_job_r  <= arm_job_nxt;
    arm_exp_r  <= arm_exp_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table: shift toward the head on a pop, open a slot on an insert.
  always_ff @(posedge clk) begin
    if (pop_en) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        tab_job_r[i] <= tab_job_r[i + 1];
        tab_exp_r[i] <= tab_exp_r[i + 1];
      end
    end
    if (ins_en) begin
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if ((CW'(i) > ins_pos) && (CW'(i) <= cnt_r)) begin
          tab_job_r[i] <= tab_job_r[i - 1];
          tab_exp_r[i] <= tab_exp_r[i - 1];
        end
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (CW'(i) == ins_pos) begin
          tab_job_r[i] <= req_r.job_id;
          tab_exp_r[i] <= req_r.expire_time;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // The fill count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("table count above depth");

  // The fill count moves by at most one entry per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1) ||
    (cnt_r + 1'b1 == $past(cnt_r)))
    else $error("table count jumped");

  // A quotient only arrives while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside its wait state");
`endif

endmodule

// ----- rtl/core/dstq_div.sv -----
// ----------------------------------------------------------------------------
// dstq_div: restoring divider for the compare value
// Divides the remaining time by the microseconds per tick, one quotient bit
// per cycle; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module dstq_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dstq_pkg::DIV_W-1:0] dividend,
  input  logic [dstq_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [dstq_pkg::DIV_W-1:0] quotient
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [dstq_pkg::DIV_CNT_W-1:0] step_r, step_nxt;
  logic [dstq_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [dstq_pkg::DSR_W-1:0]     rem_r, rem_nxt;
  logic [dstq_pkg::DSR_W-1:0]     dsr_r, dsr_nxt;
  logic [dstq_pkg::DSR_W+1:0]     trial;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {1'b0, rem_r, quo_r[dstq_pkg::DIV_W-1]} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[dstq_pkg::DSR_W+1]) begin
        rem_nxt = trial[dstq_pkg::DSR_W-1:0];
      end else begin
        rem_nxt = {rem_r[dstq_pkg::DSR_W-2:0], quo_r[dstq_pkg::DIV_W-1]};
      end
      quo_nxt  = {quo_r[dstq_pkg::DIV_W-2:0], ~trial[dstq_pkg::DSR_W+1]};
      step_nxt = step_r + 1'b1;
      if (step_r == dstq_pkg::DIV_CNT_W'(dstq_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
